### rtl/crfe_pkg.sv
package crfe_pkg;

  // Store geometry
  localparam int unsigned WIDTH  = 1024;
  localparam int unsigned HEIGHT = 768;
  localparam int unsigned XW     = $clog2(WIDTH + 1);
  localparam int unsigned YW     = $clog2(HEIGHT + 1);
  localparam int unsigned DEPTH  = WIDTH * HEIGHT;
  localparam int unsigned AW     = $clog2(DEPTH);

  localparam int unsigned CW     = 13;  // coordinate width on the input item
  localparam int unsigned PW     = 32;  // pixel width

  localparam logic [PW-1:0] BG_RESET = 32'hFF2980B9;

  // Command codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Clamp a signed coordinate into [0, lim]
  function automatic logic [CW-1:0] clamp_coord(input logic signed [CW:0] v,
                                                input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({1'b0, lim})) begin
      r = lim;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/clipped_rect_fill_engine.sv
// Steps: an accepted item moves from ST_IDLE to ST_ADDR, then to ST_FILL for a write,
//   fill or clear or to ST_READ for a read, then to ST_DONE, which registers the result.
//   An empty clipped box goes from ST_ADDR straight to ST_DONE. One item at a time:
//   input opens in the cycle after the result is taken. The fill sequencer sweeps
//   the single-port pixel memory one entry per cycle, which sets how long fill and clear take.
// Reset (rst_ni low, async): sequencer idle, no result pending, background
//   register back to 0xFF2980B9; pixel memory contents stay undefined.
module clipped_rect_fill_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [12:0] x_first, [25:13] y_first, [38:26] x_end, [51:39] y_end,
  // [83:52] color, [87:84] zero
  input  logic [87:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser_i,
  // Result item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] read_data
  output logic [31:0] m_axis_tdata_o,
  // Background color register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned XW = crfe_pkg::XW;
  localparam int unsigned YW = crfe_pkg::YW;
  localparam int unsigned AW = crfe_pkg::AW;
  localparam int unsigned CW = crfe_pkg::CW;
  localparam int unsigned PW = crfe_pkg::PW;

  localparam logic [CW-1:0] WLIM = CW'(crfe_pkg::WIDTH);
  localparam logic [CW-1:0] HLIM = CW'(crfe_pkg::HEIGHT);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [1:0]    func_q;
  logic [XW-1:0] x0_q, x1_q, x_q;
  logic [YW-1:0] y0_q, y1_q, y_q;
  logic [AW-1:0] addr_q, row_q;
  logic [PW-1:0] color_q, bg_q;
  logic [PW-1:0] rd_q;
  logic          hit_q;
  logic          out_valid_q;
  logic [PW-1:0] out_data_q;

  logic [PW-1:0] mem_q [crfe_pkg::DEPTH];

  // Unpack the item
  logic signed [CW-1:0] in_x, in_y, in_xe, in_ye;
  logic [PW-1:0]        in_color;
  logic                 in_acc, out_acc;

  assign in_x     = s_axis_tdata_i[12:0];
  assign in_y     = s_axis_tdata_i[25:13];
  assign in_xe    = s_axis_tdata_i[38:26];
  assign in_ye    = s_axis_tdata_i[51:39];
  assign in_color = s_axis_tdata_i[83:52];

  assign s_axis_tready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Bounding box of the command before clipping. A single-pixel write or
  // read is a 1x1 box, so clipping doubles as the inside test.
  logic signed [CW:0] bx0, by0, bx1, by1;
  always_comb begin
    bx0 = {in_x[CW-1], in_x};
    by0 = {in_y[CW-1], in_y};
    bx1 = bx0 + (CW+1)'(1);
    by1 = by0 + (CW+1)'(1);
    case (s_axis_tuser_i)
      crfe_pkg::FUNC_FILL: begin
        bx1 = {in_xe[CW-1], in_xe};
        by1 = {in_ye[CW-1], in_ye};
      end
      crfe_pkg::FUNC_CLEAR: begin
        bx0 = '0;
        by0 = '0;
        bx1 = $signed({1'b0, WLIM});
        by1 = $signed({1'b0, HLIM});
      end
      default: ;
    endcase
  end

  logic [CW-1:0] cx0, cy0, cx1, cy1;
  assign cx0 = crfe_pkg::clamp_coord(bx0, WLIM);
  assign cy0 = crfe_pkg::clamp_coord(by0, HLIM);
  assign cx1 = crfe_pkg::clamp_coord(bx1, WLIM);
  assign cy1 = crfe_pkg::clamp_coord(by1, HLIM);

  // Shared address unit: one constant multiply and one add
  logic          empty;
  logic [AW-1:0] base_addr;
  assign empty     = (x0_q >= x1_q) || (y0_q >= y1_q);
  assign base_addr = AW'(AW'(y0_q) * AW'(crfe_pkg::WIDTH)) + AW'(x0_q);

  // Walk of the clipped box, one pixel per cycle
  logic row_end, box_end;
  assign row_end = ((XW+1)'(x_q) + (XW+1)'(1)) == (XW+1)'(x1_q);
  assign box_end = ((YW+1)'(y_q) + (YW+1)'(1)) == (YW+1)'(y1_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ADDR;
      ST_ADDR: begin
        if (empty) begin
          state_d = ST_DONE;
        end else if (func_q == crfe_pkg::FUNC_READ) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: if (row_end && box_end) state_d = ST_DONE;
      ST_READ: state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      bg_q        <= crfe_pkg::BG_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        bg_q <= cfg_wdata_i;
      end
      // Hold the result until taken
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DONE) begin
        out_valid_q <= 1'b1;
      end
      if (in_acc) begin
        hit_q <= 1'b0;
      end else if (state_q == ST_READ) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_q  <= s_axis_tuser_i;
          x0_q    <= cx0[XW-1:0];
          y0_q    <= cy0[YW-1:0];
          x1_q    <= cx1[XW-1:0];
          y1_q    <= cy1[YW-1:0];
          color_q <= (s_axis_tuser_i == crfe_pkg::FUNC_CLEAR) ? bg_q : in_color;
        end
      end
      ST_ADDR: begin
        addr_q <= base_addr;
        row_q  <= base_addr;
        x_q    <= x0_q;
        y_q    <= y0_q;
      end
      ST_FILL: begin
        // Advance along the row, or wrap to the next row
        if (row_end) begin
          x_q    <= x0_q;
          y_q    <= y_q + YW'(1);
          row_q  <= row_q + AW'(crfe_pkg::WIDTH);
          addr_q <= row_q + AW'(crfe_pkg::WIDTH);
        end else begin
          x_q    <= x_q + XW'(1);
          addr_q <= addr_q + AW'(1);
        end
      end
      ST_DONE: begin
        out_data_q <= hit_q ? rd_q : '0;
      end
      default: ;
    endcase
  end

  // Pixel memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) begin
      mem_q[addr_q] <= color_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_q <= mem_q[addr_q];
    end
  end

  // Walk stays inside the clipped box
  a_fill_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> (x_q < x1_q) && (y_q < y1_q) && (x_q >= x0_q))
    else $error("fill walk left the clipped box");

  // Running address tracks the row-major position
  a_fill_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |->
      addr_q == AW'(AW'(y_q) * AW'(crfe_pkg::WIDTH)) + AW'(x_q))
    else $error("fill address out of step with coordinates");

  // A finished command never overwrites a pending result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !out_valid_q)
    else $error("result produced while previous one pending");

  // A read hit only comes from a read command
  a_hit_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && hit_q |-> func_q == crfe_pkg::FUNC_READ)
    else $error("read data returned for a non-read command");

endmodule

### bench/clipped_rect_fill_engine_tb.sv
`timescale 1ns / 100ps

module clipped_rect_fill_engine_tb;

  localparam int unsigned PW = crfe_pkg::PW;
  localparam int unsigned CW = crfe_pkg::CW;

  // Store bounds as signed ints so that negative coordinates compare correctly
  localparam int W = crfe_pkg::WIDTH;
  localparam int H = crfe_pkg::HEIGHT;

  // A hang shows up as a long run of cycles with no item moving on either side.
  // A clear sweeps the whole store, so allow several full sweeps.
  localparam int unsigned STALL_LIMIT  = 4 * crfe_pkg::DEPTH + 10000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned HOLD_CYCLES  = 600;

  // One command item as it travels on the input bus
  typedef struct packed {
    logic [PW-1:0]        color;
    logic signed [CW-1:0] y_end;
    logic signed [CW-1:0] x_end;
    logic signed [CW-1:0] y_first;
    logic signed [CW-1:0] x_first;
    logic [1:0]           func;
  } fb_cmd_t;

  // Shadow copy of the pixel store and the queue of read_data values it predicts
  class framebuffer_shadow;
    logic [PW-1:0] painted [int unsigned];  // pixels written since the last clear
    bit            swept;                   // whole store defined by a clear
    logic [PW-1:0] swept_color;
    logic [PW-1:0] background;
    logic [PW-1:0] read_q [$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
      background   = crfe_pkg::BG_RESET;
      swept        = 1'b0;
      swept_color  = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void paint(int x, int y, logic [PW-1:0] c);
      painted[y * W + x] = c;
    endfunction

    function int pending();
      return read_q.size();
    endfunction

    function void note_command(fb_cmd_t c);
      int xa, ya, xb, yb;
      int unsigned addr;
      logic [PW-1:0] rd;
      xa = c.x_first;
      ya = c.y_first;
      xb = c.x_end;
      yb = c.y_end;
      rd = '0;
      case (c.func)
        crfe_pkg::FUNC_WRITE: begin
          if (xa >= 0 && xa < W && ya >= 0 && ya < H) paint(xa, ya, c.color);
        end
        crfe_pkg::FUNC_FILL: begin
          // clamp the start corner up to 0 and the exclusive end down to the bounds
          if (xa < 0) xa = 0;
          if (ya < 0) ya = 0;
          if (xb > W) xb = W;
          if (yb > H) yb = H;
          for (int y = ya; y < yb; y++)
            for (int x = xa; x < xb; x++) paint(x, y, c.color);
        end
        crfe_pkg::FUNC_READ: begin
          if (xa >= 0 && xa < W && ya >= 0 && ya < H) begin
            addr = ya * W + xa;
            if (painted.exists(addr)) rd = painted[addr];
            else if (swept) rd = swept_color;
          end
        end
        crfe_pkg::FUNC_CLEAR: begin
          painted.delete();
          swept       = 1'b1;
          swept_color = background;
        end
      endcase
      read_q.push_back(rd);
    endfunction

    function void check_result(logic [PW-1:0] got);
      logic [PW-1:0] want;
      results_seen++;
      if (read_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing expected: read_data %h", got);
        return;
      end
      want = read_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("read_data mismatch on result %0d: expected %h, got %h",
                   results_seen, want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  // [12:0] x_first, [25:13] y_first, [38:26] x_end, [51:39] y_end,
  // [83:52] color, [87:84] zero
  logic [87:0] s_axis_tdata_i;
  // [1:0] func
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  // [31:0] read_data
  logic [31:0] m_axis_tdata_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  framebuffer_shadow shadow;
  bit                calm;          // both sides stop idling while set
  int unsigned       stall_cycles = 0;
  int                recent_x [$];  // points recently drawn, to aim reads at
  int                recent_y [$];

  clipped_rect_fill_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Full 13-bit signed range, so every coordinate bit toggles
  function automatic int rand_coord();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic fb_cmd_t make_cmd(logic [1:0] f, int xa, int ya, int xb, int yb,
                                       logic [PW-1:0] col);
    fb_cmd_t c;
    c.func    = f;
    c.x_first = xa[CW-1:0];
    c.y_first = ya[CW-1:0];
    c.x_end   = xb[CW-1:0];
    c.y_end   = yb[CW-1:0];
    c.color   = col;
    return c;
  endfunction

  // Remember an in-store point so later reads land on freshly drawn pixels
  function automatic void note_point(int x, int y);
    if (x >= 0 && x < W && y >= 0 && y < H) begin
      recent_x.push_back(x);
      recent_y.push_back(y);
      if (recent_x.size() > 32) begin
        void'(recent_x.pop_front());
        void'(recent_y.pop_front());
      end
    end
  endfunction

  // Offer one item; valid stays high across back-to-back items, drop it only to idle
  task automatic send_cmd(input fb_cmd_t c);
    while (!calm && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0000, c.color, c.y_end, c.x_end, c.y_first, c.x_first};
    s_axis_tuser_i  <= c.func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    shadow.note_command(c);
  endtask

  // Write the background register only once the block has gone idle
  task automatic set_background(input logic [PW-1:0] v);
    s_axis_tvalid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow.background = v;
  endtask

  // Result sink: random back-pressure, plus one long hold-off so the block fills up
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!held && shadow.results_seen >= 300) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 29);
      end
      @(posedge clk_i);
    end
  end

  // Check every accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) shadow.check_result(m_axis_tdata_o);
  end

  // Watchdog: end the run if no item moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL clipped_rect_fill_engine");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int pick, r, k;
    int xa, ya, xb, yb;
    int cx0, cy0, cx1, cy1, area;

    shadow = new();
    calm   = 1'b0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= crfe_pkg::FUNC_WRITE;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_background(32'h0000_0000);

    // Directed: corners, writes outside the store, reads of written pixels and outside the store
    send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, 0, 0, rand_coord(), rand_coord(),
                      32'hFFFF_FFFF));
    send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, W - 1, H - 1, rand_coord(), rand_coord(),
                      32'h0000_0000));
    send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, -1, 5, 0, 0, 32'hDEAD_BEEF));
    send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, W, 0, 0, 0, 32'hDEAD_BEEF));
    send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, 0, H, 0, 0, 32'hDEAD_BEEF));
    send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, -4096, 4095, 0, 0, 32'hDEAD_BEEF));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, 0, 0, rand_coord(), rand_coord(), $urandom()));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, W - 1, H - 1, rand_coord(), rand_coord(),
                      $urandom()));
    // reads outside the store answer zero
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, -4096, -4096, 0, 0, 32'h0));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, 4095, 4095, 0, 0, 32'h0));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, W, H - 1, 0, 0, 32'h0));
    // fill clipped at the top-left corner
    send_cmd(make_cmd(crfe_pkg::FUNC_FILL, -4096, -4096, 3, 2, 32'h1234_5678));
    // inverted and empty fills write nothing
    send_cmd(make_cmd(crfe_pkg::FUNC_FILL, 10, 10, 5, 20, 32'hDEAD_BEEF));
    send_cmd(make_cmd(crfe_pkg::FUNC_FILL, 10, 10, 10, 20, 32'hDEAD_BEEF));
    // fill clipped at the bottom-right corner
    send_cmd(make_cmd(crfe_pkg::FUNC_FILL, W - 4, H - 3, 4095, 4095, 32'hA5A5_5A5A));
    // fill starting right of the store is empty after clamping
    send_cmd(make_cmd(crfe_pkg::FUNC_FILL, W, 0, 4095, 10, 32'hDEAD_BEEF));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, 2, 1, 0, 0, 32'h0));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, W - 3, H - 2, 0, 0, 32'h0));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, W - 1, H - 1, 0, 0, 32'h0));

    // Clear with an all-ones background; afterward every pixel is defined
    set_background(32'hFFFF_FFFF);
    send_cmd(make_cmd(crfe_pkg::FUNC_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), $urandom()));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, 500, 400, 0, 0, 32'h0));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, 0, 0, 0, 0, 32'h0));
    send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, 7, 9, 0, 0, 32'h0F0F_F0F0));
    send_cmd(make_cmd(crfe_pkg::FUNC_READ, 7, 9, 0, 0, 32'h0));

    // Random: writes, reads aimed at recent drawing, and small or clipped fills
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 500) set_background($urandom());
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 99);
      if (pick < 35) begin
        if (r < 30) begin
          xa = rand_coord();
          ya = rand_coord();
        end else if (r < 60 && recent_x.size() > 0) begin
          k  = $urandom_range(0, recent_x.size() - 1);
          xa = recent_x[k] + int'($urandom_range(0, 2)) - 1;
          ya = recent_y[k] + int'($urandom_range(0, 2)) - 1;
        end else begin
          xa = $urandom_range(0, W - 1);
          ya = $urandom_range(0, H - 1);
        end
        send_cmd(make_cmd(crfe_pkg::FUNC_WRITE, xa, ya, rand_coord(), rand_coord(),
                          $urandom()));
        note_point(xa, ya);
      end else if (pick < 75) begin
        if (r < 50 && recent_x.size() > 0) begin
          k  = $urandom_range(0, recent_x.size() - 1);
          xa = recent_x[k];
          ya = recent_y[k];
        end else if (r < 80) begin
          xa = $urandom_range(0, W - 1);
          ya = $urandom_range(0, H - 1);
        end else begin
          xa = rand_coord();
          ya = rand_coord();
        end
        send_cmd(make_cmd(crfe_pkg::FUNC_READ, xa, ya, rand_coord(), rand_coord(),
                          $urandom()));
      end else begin
        if (r < 60) begin
          // small region near or across the store edges, sometimes inverted
          xa = int'($urandom_range(0, W + 16)) - 8;
          ya = int'($urandom_range(0, H + 16)) - 8;
          xb = xa + int'($urandom_range(0, 14)) - 2;
          yb = ya + int'($urandom_range(0, 14)) - 2;
        end else begin
          // full-range corners; retry until the clipped region is cheap to sweep
          do begin
            xa  = rand_coord();
            ya  = rand_coord();
            xb  = rand_coord();
            yb  = rand_coord();
            cx0 = (xa < 0) ? 0 : xa;
            cy0 = (ya < 0) ? 0 : ya;
            cx1 = (xb > W) ? W : xb;
            cy1 = (yb > H) ? H : yb;
            area = (cx1 > cx0 && cy1 > cy0) ? (cx1 - cx0) * (cy1 - cy0) : 0;
          end while (area > 256);
        end
        send_cmd(make_cmd(crfe_pkg::FUNC_FILL, xa, ya, xb, yb, $urandom()));
        note_point(xa, ya);
      end
    end
    calm = 1'b0;

    // Drain: wait for every predicted result, then keep clocking for DRAIN_CYCLES to catch strays
    s_axis_tvalid_i <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("PASS clipped_rect_fill_engine");
    end else begin
      $display("FAIL clipped_rect_fill_engine");
    end
    $finish;
  end

endmodule
